>>> design/prst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square tone package
// Shared widths, command and port codes and constants of the square tone
// generator.
// ----------------------------------------------------------------------------
package prst_pkg;

    localparam int RATE_W  = 17;   // half sample rate and phase accumulator
    localparam int FREQ_W  = 18;   // tone frequency, up to 97656
    localparam int DVD_W   = 19;   // dividend of the shared serial divider
    localparam int DVS_W   = 14;   // pitch divisor, 8192 - 2 * pitch
    localparam int PITCH_W = 12;
    localparam int VOL_W   = 4;
    localparam int SAMPLE_W = 5;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_PORT_WRITE = 2'd0;
    localparam cmd_t CMD_DIV_RESET  = 2'd1;
    localparam cmd_t CMD_TICK       = 2'd2;

    localparam logic [1:0] PORT_PITCH_LOW  = 2'd0;
    localparam logic [1:0] PORT_PITCH_HIGH = 2'd1;
    localparam logic [1:0] PORT_VOLUME     = 2'd2;

    localparam logic [RATE_W-1:0]  HALF_RATE_RESET = 17'd24000;
    localparam logic [PITCH_W-1:0] PITCH_OFF       = 12'hfff;
    localparam logic [DVS_W-1:0]   FREQ_BASE       = 14'd8192;
    localparam logic [DVD_W-1:0]   FREQ_NUMER      = 19'd390625;

    // Bit position of the enable in the high pitch port.
    localparam int ENABLE_BIT = 4;

endpackage : prst_pkg
`default_nettype wire

>>> design/pitch_register_square_tone.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pitch register square tone generator
// A square-wave tone source behind three byte ports, with a bit-serial
// divider shared between the pitch-to-frequency conversion and the phase
// wrap of each sample tick.
// ----------------------------------------------------------------------------
// Usage. Words arrive on the s_ channel (s_valid / s_ready): a port write,
// a divider reset or a sample tick. Only a sample tick produces a word on the
// m_ channel (m_valid / m_ready), carrying a signed five-bit sample.
// The user sets the half sample rate through cfg_wr_en / cfg_wr_data, only
// while the block is idle (the block does not enforce it); zero acts as one.
// Sequencing. One word is processed at a time. A port write to the pitch
// ports produces the frequency with a restoring divider that retires one
// quotient bit per cycle over 19 steps, except that a pitch of 0xfff sets
// the frequency to zero at once; other port writes and divider resets
// finish without leaving the idle state. A sample tick skips the divider
// when no phase wrap is needed and uses it to find the wrap count when the
// phase wraps. The sample is registered; the next word is taken as soon as
// the tick has handed its sample to the output register.
// Reset (aresetn low, synchronous) clears the ports, the frequency, the
// phase, the sign and the output valid flag, and sets the half rate to 24000.
// If the receiver stalls, a finished sample waits in the output register and
// a later tick waits until that register has been emptied.
// ----------------------------------------------------------------------------
module pitch_register_square_tone (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [prst_pkg::RATE_W-1:0]       cfg_wr_data,
    // input words
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_command,
    input  wire logic [1:0]                        s_port_index,
    input  wire logic [7:0]                        s_write_byte,
    // output samples
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [prst_pkg::SAMPLE_W-1:0]   m_sample
);

    localparam int RATE_W   = prst_pkg::RATE_W;
    localparam int FREQ_W   = prst_pkg::FREQ_W;
    localparam int DVD_W    = prst_pkg::DVD_W;
    localparam int DVS_W    = prst_pkg::DVS_W;
    localparam int PITCH_W  = prst_pkg::PITCH_W;
    localparam int VOL_W    = prst_pkg::VOL_W;
    localparam int SAMPLE_W = prst_pkg::SAMPLE_W;
    localparam int CNT_W    = $clog2(DVD_W);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [RATE_W-1:0]    half_rate_reg, half_rate_next;
    logic [7:0]           pitch_low_reg, pitch_low_next;
    logic [7:0]           pitch_high_reg, pitch_high_next;
    logic                 enable_reg, enable_next;
    logic [FREQ_W-1:0]    freq_reg, freq_next;
    logic [RATE_W-1:0]    phase_reg, phase_next;
    logic                 sign_neg_reg, sign_neg_next;
    logic [VOL_W-1:0]     volume_reg, volume_next;

    // Serial divider: dividend shifts out at the top while quotient bits
    // shift in at the bottom; the partial remainder never reaches 2^17.
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [RATE_W-1:0]    dvs_reg, dvs_next;
    logic [RATE_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 tick_mode_reg, tick_mode_next;

    logic [SAMPLE_W-1:0]  pend_reg, pend_next;
    logic                 m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0]  m_sample_reg, m_sample_next;

    logic                 accept;
    logic [7:0]           new_low, new_high;
    logic [PITCH_W-1:0]   new_pitch;
    logic [DVS_W-1:0]     pitch_dvs;
    logic [RATE_W-1:0]    rate_eff;
    logic [DVD_W-1:0]     phase_diff;
    logic [DVD_W-1:0]     deficit_m1;
    logic [SAMPLE_W-1:0]  vol_ext;
    logic [RATE_W+1:0]    trial;
    logic                 q_bit;
    logic [RATE_W-1:0]    rem_step;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    // A half rate of zero behaves as one.
    assign rate_eff = (half_rate_reg == '0) ? RATE_W'(1) : half_rate_reg;

    // Pitch as it stands after the word being accepted.
    assign new_low   = (s_port_index == prst_pkg::PORT_PITCH_LOW)  ? s_write_byte
                                                                   : pitch_low_reg;
    assign new_high  = (s_port_index == prst_pkg::PORT_PITCH_HIGH) ? s_write_byte
                                                                   : pitch_high_reg;
    assign new_pitch = {new_high[3:0], new_low};
    assign pitch_dvs = prst_pkg::FREQ_BASE - {1'b0, new_pitch, 1'b0};

    // Phase after taking off one frequency step; bit 18 flags a wrap.
    assign phase_diff = {2'b00, phase_reg} - {1'b0, freq_reg};
    assign deficit_m1 = {1'b0, freq_reg} - {2'b00, phase_reg} - DVD_W'(1);

    assign vol_ext = {1'b0, volume_reg};

    // One restoring-division step.
    assign trial    = {1'b0, rem_reg, dvd_reg[DVD_W-1]} - {2'b00, dvs_reg};
    assign q_bit    = !trial[RATE_W+1];
    assign rem_step = q_bit ? trial[RATE_W-1:0]
                            : {rem_reg[RATE_W-2:0], dvd_reg[DVD_W-1]};

    always_comb begin
        state_next      = state_reg;
        half_rate_next  = half_rate_reg;
        pitch_low_next  = pitch_low_reg;
        pitch_high_next = pitch_high_reg;
        enable_next     = enable_reg;
        freq_next       = freq_reg;
        phase_next      = phase_reg;
        sign_neg_next   = sign_neg_reg;
        volume_next     = volume_reg;
        dvd_next        = dvd_reg;
        dvs_next        = dvs_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        tick_mode_next  = tick_mode_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        m_sample_next   = m_sample_reg;

        if (cfg_wr_en) begin
            half_rate_next = cfg_wr_data;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_command)
                        prst_pkg::CMD_PORT_WRITE: begin
                            if (s_port_index == prst_pkg::PORT_PITCH_LOW ||
                                s_port_index == prst_pkg::PORT_PITCH_HIGH) begin
                                pitch_low_next  = new_low;
                                pitch_high_next = new_high;
                                if (s_port_index == prst_pkg::PORT_PITCH_HIGH) begin
                                    enable_next = s_write_byte[prst_pkg::ENABLE_BIT];
                                end
                                if (new_pitch == prst_pkg::PITCH_OFF) begin
                                    freq_next = '0;
                                end else begin
                                    dvd_next       = prst_pkg::FREQ_NUMER;
                                    dvs_next       = {{(RATE_W-DVS_W){1'b0}}, pitch_dvs};
                                    rem_next       = '0;
                                    cnt_next       = CNT_W'(DVD_W - 1);
                                    tick_mode_next = 1'b0;
                                    state_next     = ST_DIV;
                                end
                            end else if (s_port_index == prst_pkg::PORT_VOLUME) begin
                                volume_next = s_write_byte[5:2];
                            end
                        end
                        prst_pkg::CMD_DIV_RESET: begin
                            phase_next    = '0;
                            sign_neg_next = 1'b0;
                        end
                        prst_pkg::CMD_TICK: begin
                            state_next = ST_OUT;
                            if (enable_reg && freq_reg != '0) begin
                                pend_next = sign_neg_reg ? (SAMPLE_W'(0) - vol_ext)
                                                         : vol_ext;
                                if (phase_diff[DVD_W-1]) begin
                                    // Wrap count and new phase come from
                                    // (deficit - 1) divided by the rate.
                                    dvd_next       = deficit_m1;
                                    dvs_next       = rate_eff;
                                    rem_next       = '0;
                                    cnt_next       = CNT_W'(DVD_W - 1);
                                    tick_mode_next = 1'b1;
                                    state_next     = ST_DIV;
                                end else begin
                                    phase_next = phase_diff[RATE_W-1:0];
                                end
                            end else begin
                                pend_next = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                dvd_next = {dvd_reg[DVD_W-2:0], q_bit};
                rem_next = rem_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    if (tick_mode_reg) begin
                        // The number of additions is quotient + 1, so an even
                        // quotient means an odd number of sign flips.
                        phase_next = dvs_reg - RATE_W'(1) - rem_step;
                        if (!q_bit) begin
                            sign_neg_next = !sign_neg_reg;
                        end
                        state_next = ST_OUT;
                    end else begin
                        freq_next  = {dvd_reg[FREQ_W-2:0], q_bit};
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = pend_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            half_rate_reg  <= prst_pkg::HALF_RATE_RESET;
            pitch_low_reg  <= '0;
            pitch_high_reg <= '0;
            enable_reg     <= 1'b0;
            freq_reg       <= '0;
            phase_reg      <= '0;
            sign_neg_reg   <= 1'b0;
            volume_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            half_rate_reg  <= half_rate_next;
            pitch_low_reg  <= pitch_low_next;
            pitch_high_reg <= pitch_high_next;
            enable_reg     <= enable_next;
            freq_reg       <= freq_next;
            phase_reg      <= phase_next;
            sign_neg_reg   <= sign_neg_next;
            volume_reg     <= volume_next;
            m_valid_reg    <= m_valid_next;
        end
        // Datapath registers need no reset.
        dvd_reg       <= dvd_next;
        dvs_reg       <= dvs_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        tick_mode_reg <= tick_mode_next;
        pend_reg      <= pend_next;
        m_sample_reg  <= m_sample_next;
    end

endmodule : pitch_register_square_tone
`default_nettype wire
